FILE: rtl/scatter_gather_completion_tracker_assert.svh
// Assertion macros used by the tracker datapath (sgct_dp).
`ifndef SCATTER_GATHER_COMPLETION_TRACKER_ASSERT_SVH
`define SCATTER_GATHER_COMPLETION_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define SGCT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SGCT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SGCT_ASSERT(lbl, clk, rst_n, prop, msg)
`define SGCT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/sgct_pkg.sv
`timescale 1ns / 1ps
package sgct_pkg;

	localparam int MAX_SERVERS = 64;
	localparam int TIMER_BITS  = 32;
	localparam int IDX_W       = $clog2(MAX_SERVERS);
	localparam int CNT_W       = 7;
	localparam logic [31:0] CACHE_TICKS_RST = 32'd250;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_REPLY = 2'd1,
		CMD_FAIL  = 2'd2,
		CMD_TICK  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_PROTO = 2'd1,
		ST_BUSY  = 2'd2
	} status_t;

	typedef enum logic {
		OS_EMPTY,
		OS_FULL
	} out_state_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [6:0]  server_count;
		logic [5:0]  server_index;
		logic        size_ok;
		logic [7:0]  fail_code;
		logic [63:0] allocated_in;
		logic [63:0] inodes_in;
		logic [63:0] total_in;
	} in_t;

	typedef struct packed {
		status_t     status;
		logic        complete;
		logic [6:0]  pending_count;
		logic [7:0]  round_error;
		logic [63:0] allocated_sum;
		logic [63:0] inodes_sum;
		logic [63:0] total_sum;
	} out_t;

	typedef struct packed {
		logic exec;
	} dp_cmd_t;

endpackage

FILE: rtl/sgct_ctrl.sv
`timescale 1ns / 1ps
module sgct_ctrl
	import sgct_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    out_stall,
	output logic    in_stall,
	output logic    out_valid,
	output dp_cmd_t dp_cmd
);

	out_state_t state_q;
	out_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= OS_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			OS_EMPTY: begin
				if (in_valid) begin
					state_d = OS_FULL;
				end
			end
			OS_FULL: begin
				if (!out_stall && !in_valid) begin
					state_d = OS_EMPTY;
				end
			end
			default: begin
				state_d = OS_EMPTY;
			end
		endcase
	end

	always_comb begin
		in_stall    = 1'b0;
		out_valid   = 1'b0;
		unique case (state_q)
			OS_EMPTY: begin
				in_stall  = 1'b0;
				out_valid = 1'b0;
			end
			OS_FULL: begin
				in_stall  = out_stall;
				out_valid = 1'b1;
			end
			default: begin
				in_stall  = 1'b1;
				out_valid = 1'b0;
			end
		endcase
		dp_cmd.exec = in_valid && !in_stall;
	end

endmodule

FILE: rtl/sgct_dp.sv
`timescale 1ns / 1ps
`include "scatter_gather_completion_tracker_assert.svh"
module sgct_dp
	import sgct_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     dp_cmd,
	input  in_t         in_data,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	output out_t        out_data
);

	logic [31:0]            cache_ticks_q;
	logic [MAX_SERVERS-1:0] pending_bits_q;
	logic [CNT_W-1:0]       pending_total_q;
	logic [CNT_W-1:0]       round_count_q;
	logic [7:0]             first_error_q;
	logic [63:0]            sum_alloc_q;
	logic [63:0]            sum_inodes_q;
	logic [63:0]            sum_total_q;
	logic [TIMER_BITS-1:0]  timer_q;
	out_t                   out_q;

	logic [MAX_SERVERS-1:0] pending_bits_d;
	logic [CNT_W-1:0]       pending_total_d;
	logic [CNT_W-1:0]       round_count_d;
	logic [7:0]             first_error_d;
	logic [63:0]            sum_alloc_d;
	logic [63:0]            sum_inodes_d;
	logic [63:0]            sum_total_d;
	logic [TIMER_BITS-1:0]  timer_d;
	status_t                status_d;
	logic [CNT_W-1:0]       start_count;
	logic                   idx_ok;
	logic                   retire;
	logic [7:0]             retire_err;
	logic [IDX_W-1:0]       idx;

	assign idx    = in_data.server_index[IDX_W-1:0];
	assign idx_ok = (CNT_W'(in_data.server_index) < round_count_q) && pending_bits_q[idx];
	assign start_count = (in_data.server_count > CNT_W'(MAX_SERVERS)) ?
		CNT_W'(MAX_SERVERS) : in_data.server_count;

	always_comb begin
		pending_bits_d  = pending_bits_q;
		pending_total_d = pending_total_q;
		round_count_d   = round_count_q;
		first_error_d   = first_error_q;
		sum_alloc_d     = sum_alloc_q;
		sum_inodes_d    = sum_inodes_q;
		sum_total_d     = sum_total_q;
		timer_d         = timer_q;
		status_d        = ST_OK;
		retire          = 1'b0;
		retire_err      = 8'd0;
		unique case (in_data.cmd)
			CMD_START: begin
				if (timer_q != '0 || pending_total_q != '0) begin
					status_d = ST_BUSY;
				end else begin
					round_count_d = start_count;
					for (int i = 0; i < MAX_SERVERS; i++) begin
						pending_bits_d[i] = CNT_W'(i) < start_count;
					end
					pending_total_d = start_count;
					first_error_d   = 8'd0;
					sum_alloc_d     = 64'd0;
					sum_inodes_d    = 64'd0;
					sum_total_d     = 64'd0;
				end
			end
			CMD_REPLY: begin
				if (!in_data.size_ok || !idx_ok) begin
					status_d = ST_PROTO;
				end else begin
					retire      = 1'b1;
					sum_alloc_d  = sum_alloc_q + in_data.allocated_in;
					sum_inodes_d = sum_inodes_q + in_data.inodes_in;
					sum_total_d  = sum_total_q + in_data.total_in;
				end
			end
			CMD_FAIL: begin
				if (!idx_ok) begin
					status_d = ST_PROTO;
				end else begin
					retire     = 1'b1;
					retire_err = in_data.fail_code;
				end
			end
			CMD_TICK: begin
				if (timer_q != '0) begin
					timer_d = timer_q - TIMER_BITS'(1);
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
		if (retire) begin
			pending_bits_d[idx] = 1'b0;
			if (retire_err != 8'd0 && first_error_q == 8'd0) begin
				first_error_d = retire_err;
			end
			pending_total_d = pending_total_q - CNT_W'(1);
			if (pending_total_q == CNT_W'(1)) begin
				timer_d = TIMER_BITS'(cache_ticks_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_ticks_q <= CACHE_TICKS_RST;
		end else if (cfg_wr_en) begin
			cache_ticks_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_bits_q  <= '0;
			pending_total_q <= '0;
			round_count_q   <= '0;
			first_error_q   <= '0;
			sum_alloc_q     <= '0;
			sum_inodes_q    <= '0;
			sum_total_q     <= '0;
			timer_q         <= '0;
		end else if (dp_cmd.exec) begin
			pending_bits_q  <= pending_bits_d;
			pending_total_q <= pending_total_d;
			round_count_q   <= round_count_d;
			first_error_q   <= first_error_d;
			sum_alloc_q     <= sum_alloc_d;
			sum_inodes_q    <= sum_inodes_d;
			sum_total_q     <= sum_total_d;
			timer_q         <= timer_d;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.exec) begin
			out_q.status        <= status_d;
			out_q.complete      <= timer_d != '0;
			out_q.pending_count <= pending_total_d;
			out_q.round_error   <= first_error_d;
			out_q.allocated_sum <= sum_alloc_d;
			out_q.inodes_sum    <= sum_inodes_d;
			out_q.total_sum     <= sum_total_d;
		end
	end

	assign out_data = out_q;

	`SGCT_ASSERT(a_count_matches_bits, clk, arst_n, CNT_W'($countones(pending_bits_q)) == pending_total_q, "pending count differs from pending bits")
	`SGCT_ASSERT(a_timer_only_when_idle, clk, arst_n, (timer_q != '0) |-> (pending_total_q == '0), "result window open while servers pending")
	`SGCT_ASSERT(a_total_within_round, clk, arst_n, pending_total_q <= round_count_q, "pending count above round size")

endmodule

FILE: rtl/scatter_gather_completion_tracker.sv
// Channel   Handshake                 Payload
// in        in_valid / in_stall       in_data (in_t)
// out       out_valid / out_stall     out_data (out_t)
// cfg       cfg_wr_en                 cfg_wr_data (cache_ticks)
// Each transfer is applied to the tracking state in the cycle it is accepted.
// Its result is held in one output register and one input transfer is taken per cycle while in_stall is low.
// A new input is accepted whenever the output register is empty or drains in the same cycle.
// Reset clears all pending bits, counts, sums and the validity timer.
`timescale 1ns / 1ps
module scatter_gather_completion_tracker
	import sgct_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data
);

	dp_cmd_t dp_cmd;

	sgct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.dp_cmd    (dp_cmd)
	);

	sgct_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.dp_cmd      (dp_cmd),
		.in_data     (in_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_data    (out_data)
	);

endmodule
